>>> rtl/bpcp_pkg.sv
package bpcp_pkg;

  localparam int ADC_BITS          = 10;
  localparam int FRAC_BITS_DEF     = 16;
  localparam int KEY_COUNT_DEF     = 12;
  localparam int KEY_W             = 4;
  localparam int HOLD_W            = 16;
  localparam int BUTTONS           = 3;

  localparam logic [HOLD_W-1:0]   DEBOUNCE_RST = HOLD_W'(20);
  localparam logic [HOLD_W-1:0]   HOLD_MAX     = '1;
  // filter start points: mid scale and full scale
  localparam logic [ADC_BITS-1:0] RETUNE_RST   = {1'b1, {(ADC_BITS-1){1'b0}}};
  localparam logic [ADC_BITS-1:0] CORR_RST     = '1;

  // button positions within the per-button vectors
  localparam int BTN_UP    = 0;
  localparam int BTN_DOWN  = 1;
  localparam int BTN_SCALE = 2;

  typedef struct packed {
    logic                key_up_pin;
    logic                key_down_pin;
    logic                scale_pin;
    logic [ADC_BITS-1:0] retune_sample;
    logic [ADC_BITS-1:0] correction_sample;
  } in_word_t;

  typedef struct packed {
    logic [KEY_W-1:0]    current_key;
    logic                scale_toggle_pulse;
    logic [ADC_BITS-1:0] retune_level;
    logic [ADC_BITS-1:0] correction_level;
  } out_word_t;

endpackage

>>> rtl/bpcp_debounce.sv
// One button: hold counter restarted on every raw level change.
module bpcp_debounce (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       pin,
  input  logic [bpcp_pkg::HOLD_W-1:0] ticks,
  output logic                       press
);

  logic                        last_r, last_nxt;
  logic                        stable_r, stable_nxt;
  logic [bpcp_pkg::HOLD_W-1:0] cnt_r, cnt_nxt;
  logic                        pressed;
  logic                        take;

  assign pressed = ~pin;

  always_comb begin
    last_nxt = pressed;
    if (pressed != last_r) begin
      cnt_nxt = '0;
    end else if (cnt_r == bpcp_pkg::HOLD_MAX) begin
      cnt_nxt = cnt_r;
    end else begin
      cnt_nxt = cnt_r + 1'b1;
    end
    take       = (cnt_nxt >= ticks) && (pressed != stable_r);
    stable_nxt = take ? pressed : stable_r;
    press      = take & pressed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= 1'b0;
      stable_r <= 1'b0;
      cnt_r    <= bpcp_pkg::HOLD_MAX;
    end else if (adv) begin
      last_r   <= last_nxt;
      stable_r <= stable_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> rtl/bpcp_iir.sv
// One-pole low-pass, s' = s + round((x - s) * alpha), alpha = 0.1 in FRAC_BITS.
module bpcp_iir #(
  parameter int                            FRAC_BITS   = bpcp_pkg::FRAC_BITS_DEF,
  parameter logic [bpcp_pkg::ADC_BITS-1:0] RESET_LEVEL = bpcp_pkg::RETUNE_RST
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic [bpcp_pkg::ADC_BITS-1:0] sample,
  output logic [bpcp_pkg::ADC_BITS-1:0] level
);

  localparam int S = bpcp_pkg::ADC_BITS + FRAC_BITS;
  localparam int P = S + FRAC_BITS + 2;
  localparam int unsigned ALPHA = ((1 << FRAC_BITS) + 5) / 10;
  localparam logic [FRAC_BITS-1:0] ALPHA_Q = ALPHA[FRAC_BITS-1:0];
  localparam logic [P-1:0]         HALF    = P'(1) << (FRAC_BITS - 1);
  localparam logic [S-1:0]         S_RST   = {RESET_LEVEL, {FRAC_BITS{1'b0}}};

  logic        [S-1:0] s_r, s_nxt;
  logic signed [S:0]   diff;
  logic signed [P-1:0] prod, rnd, step;
  logic        [S:0]   sum;

  always_comb begin
    diff  = $signed({1'b0, sample, {FRAC_BITS{1'b0}}}) - $signed({1'b0, s_r});
    prod  = diff * $signed({1'b0, ALPHA_Q});
    rnd   = prod + $signed(HALF);
    step  = rnd >>> FRAC_BITS;
    sum   = {1'b0, s_r} + step[S:0];
    s_nxt = sum[S-1:0];
    level = s_nxt[S-1:FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= S_RST;
    end else if (adv) begin
      s_r <= s_nxt;
    end
  end

endmodule

>>> rtl/button_pot_control_panel.sv
// Channel | Direction | Handshake            | Word
// --------+-----------+----------------------+-------------------------------
// in_     | input     | in_valid / in_ready  | bpcp_pkg::in_word_t, one tick
// out_    | output    | out_valid / out_ready| bpcp_pkg::out_word_t, one tick
// cfg_    | input     | cfg_wr_en            | debounce_ticks, 16 bit
//
// One word per cycle sustained while out_ready is high; a word's result goes
// from the input register into the result register, which drives out_word.
// The single path: debounce compare, key step and one 27x17 filter multiply.
// rst_n is synchronous, active low; it restores all button, key and filter state.
// A stalled out_ word holds the result register; in_ready stays high while
// the input register is empty or its word can move on.
module button_pot_control_panel #(
  parameter int FRAC_BITS = bpcp_pkg::FRAC_BITS_DEF,
  parameter int KEY_COUNT = bpcp_pkg::KEY_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bpcp_pkg::in_word_t            in_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bpcp_pkg::out_word_t           out_word,
  input  logic                          cfg_wr_en,
  input  logic [bpcp_pkg::HOLD_W-1:0]   cfg_wr_data
);

  localparam logic [bpcp_pkg::KEY_W-1:0] KEY_LAST = bpcp_pkg::KEY_W'(KEY_COUNT - 1);

  // debounce threshold register
  logic [bpcp_pkg::HOLD_W-1:0] ticks_r;

  // input register
  logic                 s1_valid_r;
  bpcp_pkg::in_word_t   s1_word_r;

  // result register
  logic                 out_valid_r;
  bpcp_pkg::out_word_t  out_word_r, out_word_nxt;

  logic [bpcp_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [bpcp_pkg::BUTTONS-1:0] pins, press;
  logic [bpcp_pkg::ADC_BITS-1:0] retune_lvl, corr_lvl;
  logic adv;

  // word leaves the input register when the result slot is free or draining
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= bpcp_pkg::DEBOUNCE_RST;
    end else if (cfg_wr_en) begin
      ticks_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word_r <= in_word;
    end
  end

  // --- buttons ---
  assign pins[bpcp_pkg::BTN_UP]    = s1_word_r.key_up_pin;
  assign pins[bpcp_pkg::BTN_DOWN]  = s1_word_r.key_down_pin;
  assign pins[bpcp_pkg::BTN_SCALE] = s1_word_r.scale_pin;

  for (genvar b = 0; b < bpcp_pkg::BUTTONS; b++) begin : g_btn
    bpcp_debounce u_deb (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .pin   (pins[b]),
      .ticks (ticks_r),
      .press (press[b])
    );
  end

  // key steps up first, then down: both on one tick cancel out
  always_comb begin
    key_nxt = key_r;
    if (press[bpcp_pkg::BTN_UP]) begin
      key_nxt = (key_nxt == KEY_LAST) ? '0 : key_nxt + 1'b1;
    end
    if (press[bpcp_pkg::BTN_DOWN]) begin
      key_nxt = (key_nxt == '0) ? KEY_LAST : key_nxt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (adv) begin
      key_r <= key_nxt;
    end
  end

  // --- pots ---
  bpcp_iir #(
    .FRAC_BITS   (FRAC_BITS),
    .RESET_LEVEL (bpcp_pkg::RETUNE_RST)
  ) u_retune (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .sample (s1_word_r.retune_sample),
    .level  (retune_lvl)
  );

  bpcp_iir #(
    .FRAC_BITS   (FRAC_BITS),
    .RESET_LEVEL (bpcp_pkg::CORR_RST)
  ) u_corr (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .sample (s1_word_r.correction_sample),
    .level  (corr_lvl)
  );

  // --- result register ---
  always_comb begin
    out_word_nxt.current_key        = key_nxt;
    out_word_nxt.scale_toggle_pulse = press[bpcp_pkg::BTN_SCALE];
    out_word_nxt.retune_level       = retune_lvl;
    out_word_nxt.correction_level   = corr_lvl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word_r <= out_word_nxt;
    end
  end

  // --- checks ---
  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_word_r.current_key <= KEY_LAST))
    else $error("key index beyond last key");

  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input held off without a stalled result");

  a_adv_fills: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("advanced word did not reach the result register");

endmodule

>>> dv/tb_button_pot_control_panel.sv
`timescale 1ns / 1ps

// Self-checking bench for the control panel: three debounced buttons, a key
// register and two IIR-smoothed pot readings. Every accepted input word is run
// through an in-bench predictor. Its result is queued and compared, field by
// field, with the word that comes out.
module tb_button_pot_control_panel;
  import bpcp_pkg::*;

  // Filter arithmetic at the block's default widths
  localparam int FRAC = FRAC_BITS_DEF;
  localparam int SMOOTH_W = ADC_BITS + FRAC;
  localparam longint unsigned Q_ONE = 64'd1 << FRAC;
  localparam longint unsigned Q_ALPHA = (Q_ONE + 5) / 10;   // 0.1, rounded

  localparam int IDLE_LIMIT = 2000;      // cycles with no word moving either way
  localparam int LONG_HOLD_OFF = 300;    // long receiver stall, in cycles
  localparam int SHOWN_FAULTS = 30;      // mismatches printed before going quiet
  localparam int LONG_THRESHOLD = 40;    // threshold for the long held press

  // Receiver stall patterns
  typedef enum int {RX_ALWAYS, RX_HALF, RX_MOSTLY, RX_SPARSE} rx_pattern_e;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_word_t            in_word = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_word_t           out_word;
  logic                cfg_wr_en = 1'b0;
  logic [HOLD_W-1:0]   cfg_wr_data = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  button_pot_control_panel i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_word    (out_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the panel
  // ---------------------------------------------------------------------------
  logic [HOLD_W-1:0]   hold_limit;          // debounce threshold in ticks
  logic [KEY_W-1:0]    key_model;
  logic                btn_last   [BUTTONS]; // 1 = pressed
  logic                btn_stable [BUTTONS];
  logic [HOLD_W-1:0]   btn_hold   [BUTTONS];
  logic [SMOOTH_W-1:0] retune_acc;
  logic [SMOOTH_W-1:0] corr_acc;

  out_word_t           expected_results[$];
  out_word_t           due_word;

  int fault_count = 0;
  int ticks_taken = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int key_moves = 0;
  int pulses_due = 0;

  // Stimulus state: raw pin levels with the ticks left in their current run,
  // and pot readings held for runs so the filters get to settle now and then
  logic                btn_pin [BUTTONS];
  int                  btn_run [BUTTONS];
  logic [ADC_BITS-1:0] smp_val [2];
  int                  smp_run [2];

  bit gaps_on = 1'b1;
  int burst_left = 0;
  int stall_req = 0;

  task automatic reset_model;
    hold_limit = DEBOUNCE_RST;
    key_model = '0;
    for (int b = 0; b < BUTTONS; b++) begin
      btn_last[b] = 1'b0;
      btn_stable[b] = 1'b0;
      btn_hold[b] = HOLD_MAX;
      btn_pin[b] = 1'b1;
      btn_run[b] = 0;
    end
    retune_acc = {RETUNE_RST, {FRAC{1'b0}}};
    corr_acc = {CORR_RST, {FRAC{1'b0}}};
    smp_run[0] = 0;
    smp_run[1] = 0;
  endtask

  // One button for one tick; returns 1 on a confirmed press.
  // A level change restarts the hold count, which saturates rather than wraps.
  function automatic logic confirm_press(int b, logic pin);
    logic pressed;
    pressed = ~pin;
    if (pressed != btn_last[b]) begin
      btn_last[b] = pressed;
      btn_hold[b] = '0;
    end else if (btn_hold[b] != HOLD_MAX) begin
      btn_hold[b] = btn_hold[b] + 1'b1;
    end
    if (btn_hold[b] >= hold_limit && pressed != btn_stable[b]) begin
      btn_stable[b] = pressed;
      return pressed;
    end
    return 1'b0;
  endfunction

  // One-pole low-pass, alpha = 0.1, rounded to nearest before truncation
  function automatic logic [SMOOTH_W-1:0] iir_step(logic [SMOOTH_W-1:0] acc_in,
                                                  logic [ADC_BITS-1:0] sample);
    logic [63:0] sum;
    sum = 64'(acc_in) * (Q_ONE - Q_ALPHA) + (64'(sample) << FRAC) * Q_ALPHA
        + (Q_ONE >> 1);
    return SMOOTH_W'(sum >> FRAC);
  endfunction

  // Whole tick: up step first, then down step, so a double press cancels out
  function automatic out_word_t predict_tick(in_word_t w);
    out_word_t        r;
    logic [KEY_W-1:0] was;
    was = key_model;
    if (confirm_press(BTN_UP, w.key_up_pin))
      key_model = (key_model == KEY_W'(KEY_COUNT_DEF - 1)) ? '0 : key_model + 1'b1;
    if (confirm_press(BTN_DOWN, w.key_down_pin))
      key_model = (key_model == '0) ? KEY_W'(KEY_COUNT_DEF - 1) : key_model - 1'b1;
    r.scale_toggle_pulse = confirm_press(BTN_SCALE, w.scale_pin);
    retune_acc = iir_step(retune_acc, w.retune_sample);
    corr_acc = iir_step(corr_acc, w.correction_sample);
    r.current_key = key_model;
    r.retune_level = retune_acc[SMOOTH_W-1 -: ADC_BITS];
    r.correction_level = corr_acc[SMOOTH_W-1 -: ADC_BITS];
    if (key_model != was) key_moves++;
    if (r.scale_toggle_pulse) pulses_due++;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking: expectations are queued on input acceptance, popped on output
  // acceptance. Results are registered, so order within the block is safe.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    if (fault_count < SHOWN_FAULTS) $display("[%0t] mismatch: %s", $realtime, msg);
    fault_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result word %0d arrived with nothing expected",
                                    results_seen));
        end else begin
          due_word = expected_results.pop_front();
          if (out_word.current_key !== due_word.current_key)
            report_mismatch($sformatf("word %0d current_key got %0d, expected %0d",
                            results_seen, out_word.current_key, due_word.current_key));
          if (out_word.scale_toggle_pulse !== due_word.scale_toggle_pulse)
            report_mismatch($sformatf("word %0d scale_toggle_pulse got %0b, expected %0b",
                            results_seen, out_word.scale_toggle_pulse,
                            due_word.scale_toggle_pulse));
          if (out_word.retune_level !== due_word.retune_level)
            report_mismatch($sformatf("word %0d retune_level got %0d, expected %0d",
                            results_seen, out_word.retune_level, due_word.retune_level));
          if (out_word.correction_level !== due_word.correction_level)
            report_mismatch($sformatf("word %0d correction_level got %0d, expected %0d",
                            results_seen, out_word.correction_level,
                            due_word.correction_level));
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_tick(in_word));
        ticks_taken++;
      end
    end
  end

  // Watchdog: any word moving on either side resets the count
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d results still due",
               IDLE_LIMIT, expected_results.size());
      $display("** button_pot_control_panel: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: a fresh random ready mask for each lap through its bits, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  int          stall_left = 0;
  int          ready_phase = 0;
  rx_pattern_e ready_mode = RX_ALWAYS;
  logic [31:0] ready_mask = '1;

  always @(negedge clk) begin
    if (stall_req != 0) begin
      stall_left = stall_req;
      stall_req = 0;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready = 1'b0;
    end else begin
      if (ready_phase == 0) begin
        ready_mask = $urandom;
        ready_mode = rx_pattern_e'($urandom_range(0, 3));
      end
      case (ready_mode)
        RX_ALWAYS: out_ready = 1'b1;
        RX_HALF:   out_ready = ready_mask[ready_phase];
        RX_MOSTLY: out_ready = ready_mask[ready_phase] | ready_mask[(ready_phase + 7) % 32];
        default:   out_ready = ready_mask[ready_phase] & ready_mask[(ready_phase + 7) % 32];
      endcase
      ready_phase = (ready_phase + 1) % 32;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // Offers one word at the falling edge and returns at the rising edge that
  // takes it. Valid is only dropped for a gap between bursts, so a word that
  // follows straight on keeps valid high through the step.
  task automatic send_tick(input in_word_t w);
    int gap;
    @(negedge clk);
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    if (burst_left != 0) burst_left--;
    in_valid = 1'b1;
    in_word = w;
    do @(posedge clk); while (!in_ready);
  endtask

  // Sender stops and waits for every due result; the block is idle afterwards
  task automatic wait_drained;
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Only ever called with the block idle
  task automatic set_debounce(input logic [HOLD_W-1:0] ticks);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = ticks;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    hold_limit = ticks;
    cfg_writes++;
  endtask

  function automatic in_word_t make_tick(bit up, bit down, bit scale,
                                         logic [ADC_BITS-1:0] retune,
                                         logic [ADC_BITS-1:0] corr);
    in_word_t w;
    w.key_up_pin = ~up;          // pins are active low
    w.key_down_pin = ~down;
    w.scale_pin = ~scale;
    w.retune_sample = retune;
    w.correction_sample = corr;
    return w;
  endfunction

  // Run length for a pin level: mostly long enough to be taken, one in five a
  // bounce a nonzero threshold rejects. Huge thresholds only see short runs.
  function automatic int pick_run();
    int t;
    t = int'(hold_limit);
    if (t > 40) return $urandom_range(1, 40);
    if ($urandom_range(0, 4) == 0) return $urandom_range(1, (t == 0) ? 1 : t);
    return t + $urandom_range(1, 8);
  endfunction

  // Pot readings: short runs of random values, now and then a long steady
  // stretch, with the rails well represented
  function automatic logic [ADC_BITS-1:0] next_sample(int ch);
    if (smp_run[ch] == 0) begin
      smp_run[ch] = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                : $urandom_range(1, 6);
      case ($urandom_range(0, 5))
        0:       smp_val[ch] = '0;
        1:       smp_val[ch] = '1;
        default: smp_val[ch] = ADC_BITS'($urandom);
      endcase
    end
    smp_run[ch]--;
    return smp_val[ch];
  endfunction

  function automatic in_word_t gen_random_tick();
    in_word_t w;
    for (int b = 0; b < BUTTONS; b++) begin
      if (btn_run[b] == 0) begin
        btn_pin[b] = ~btn_pin[b];
        btn_run[b] = pick_run();
      end
      btn_run[b]--;
    end
    w.key_up_pin = btn_pin[BTN_UP];
    w.key_down_pin = btn_pin[BTN_DOWN];
    w.scale_pin = btn_pin[BTN_SCALE];
    w.retune_sample = next_sample(0);
    w.correction_sample = next_sample(1);
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Zero threshold: every change is taken on its own tick. Covers key wrap both
  // ways, up and down on one tick, a scale press held past its pulse, and pot
  // readings at the rails. Then threshold 1 with a one-tick bounce.
  task automatic test_directed_edges;
    set_debounce('0);
    send_tick(make_tick(0, 0, 0, 0, 1023));
    send_tick(make_tick(1, 0, 0, 1023, 0));       // key 1
    send_tick(make_tick(0, 0, 0, 512, 511));
    send_tick(make_tick(0, 1, 0, 1, 1022));       // key 0
    send_tick(make_tick(0, 0, 0, 1023, 1023));
    send_tick(make_tick(0, 1, 0, 0, 0));          // wraps down to 11
    send_tick(make_tick(0, 0, 0, 1023, 0));
    send_tick(make_tick(1, 0, 0, 0, 1023));       // wraps up to 0
    send_tick(make_tick(0, 0, 0, 682, 341));
    send_tick(make_tick(1, 1, 0, 1023, 1023));    // both at once: no net step
    send_tick(make_tick(0, 0, 0, 0, 0));
    send_tick(make_tick(0, 0, 1, 1023, 1023));    // scale pulse
    send_tick(make_tick(0, 0, 1, 1023, 1023));    // held: no second pulse
    send_tick(make_tick(0, 0, 0, 1023, 1023));
    wait_drained;
    set_debounce(HOLD_W'(1));
    send_tick(make_tick(1, 0, 0, 5, 1000));       // restarts count, not yet taken
    send_tick(make_tick(0, 0, 0, 5, 1000));       // bounce back
    send_tick(make_tick(1, 0, 0, 5, 1000));
    send_tick(make_tick(1, 0, 0, 5, 1000));       // held one tick: taken
    send_tick(make_tick(0, 0, 0, 5, 1000));
    send_tick(make_tick(0, 0, 0, 5, 1000));
  endtask

  // Random pin runs and pot readings under a spread of thresholds
  task automatic test_random_settings;
    logic [HOLD_W-1:0] plan [7];
    plan = '{HOLD_W'(0), HOLD_W'(1), HOLD_W'(2), HOLD_W'(5), DEBOUNCE_RST,
             HOLD_W'($urandom_range(3, 12)), HOLD_MAX};
    for (int i = 0; i < 7; i++) begin
      wait_drained;
      set_debounce(plan[i]);
      repeat ((plan[i] == HOLD_MAX) ? 150 : 280) send_tick(gen_random_tick());
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering;
  // the block fills and must stall its input without losing a word
  task automatic test_backpressure;
    wait_drained;
    set_debounce(HOLD_W'(2));
    gaps_on = 1'b0;
    stall_req = LONG_HOLD_OFF;
    repeat (80) send_tick(gen_random_tick());
    gaps_on = 1'b1;
    wait_drained;
  endtask

  // Long threshold: up and scale pressed together and held just past it, then
  // released for as long; each edge is taken only once the count gets there.
  task automatic test_long_hold;
    wait_drained;
    set_debounce('0);
    send_tick(make_tick(0, 0, 0, next_sample(0), next_sample(1)));   // all released
    wait_drained;
    set_debounce(HOLD_W'(LONG_THRESHOLD));
    gaps_on = 1'b0;
    repeat (LONG_THRESHOLD + 2)
      send_tick(make_tick(1, 0, 1, next_sample(0), next_sample(1)));
    repeat (LONG_THRESHOLD + 2)
      send_tick(make_tick(0, 0, 0, next_sample(0), next_sample(1)));
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    reset_model;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_edges;
    test_random_settings;
    test_backpressure;
    test_long_hold;

    wait_drained;
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    $display("Run: %0d ticks, %0d results checked, %0d threshold writes from 0 up to 65535.",
             ticks_taken, results_seen, cfg_writes);
    $display("Seen: %0d key steps, %0d scale pulses, a long output stall; %0d mismatches.",
             key_moves, pulses_due, fault_count);
    if (fault_count == 0) begin
      $display("** button_pot_control_panel: PASSED **");
    end else begin
      $display("** button_pot_control_panel: FAILED **");
    end
    $finish;
  end

endmodule

>>> button_pot_control_panel.f
rtl/bpcp_pkg.sv
rtl/bpcp_debounce.sv
rtl/bpcp_iir.sv
rtl/button_pot_control_panel.sv
dv/tb_button_pot_control_panel.sv
